// ===== design/euler_totient_top_assert.svh =====
// Assertion macros shared by the checker files of the totient block.
// Each macro writes one labeled concurrent assertion, sampled on the
// rising clock edge and switched off while reset is high.
`ifndef EULER_TOTIENT_TOP_ASSERT_SVH
`define EULER_TOTIENT_TOP_ASSERT_SVH

// Same-cycle implication.
`define ETOT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ETOT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/etot_pkg.sv =====
// ----------------------------------------------------------------------------
// etot_pkg
// Shared constants and command/status types of the totient block.
// ----------------------------------------------------------------------------
package etot_pkg;

   // Default width of the value and result fields
   localparam int VALUE_BITS_DEFAULT = 20;

   // Divider operand selection
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_SEL_REST_CAND = 2'd0;  // rest / candidate
   localparam div_sel_type DIV_SEL_ACC_CAND  = 2'd1;  // acc / candidate
   localparam div_sel_type DIV_SEL_ACC_REST  = 2'd2;  // acc / remaining cofactor

   // Commands from the controller to the datapath
   typedef struct packed {
      logic        load;       // take a new value, restart the search
      logic        div_start;  // launch the divider on the selected operands
      div_sel_type div_sel;
      logic        rest_upd;   // rest <= quotient
      logic        hit_set;    // mark candidate as a factor
      logic        acc_upd;    // acc <= acc - quotient
      logic        advance;    // step to the next candidate
   } etot_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic sq_le_rest;  // candidate squared does not exceed rest
      logic rest_gt1;    // remaining cofactor above one
      logic div_done;    // divider result valid this cycle
      logic rem_zero;    // divider remainder is zero
      logic hit;         // current candidate divided rest at least once
   } etot_stat_type;

endpackage

// ===== design/etot_div.sv =====
// ----------------------------------------------------------------------------
// etot_div
// Restoring unsigned divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module etot_div #(
   parameter int VALUE_BITS = etot_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-1:0] quotient,
   output logic [VALUE_BITS-1:0] remainder
);

   localparam int ITER  = (VALUE_BITS + 1) / 2;
   localparam int DQ_W  = 2 * ITER;
   localparam int CNT_W = $clog2(ITER + 1);

   logic [DQ_W-1:0]       dq_ff, dq_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  done_ff, done_in;

   // Two restoring steps per cycle; shift dividend bits into the remainder
   always_comb begin
      logic [VALUE_BITS:0]   trial;
      logic [VALUE_BITS-1:0] r;
      logic [DQ_W-1:0]       d;
      r = rem_ff;
      d = dq_ff;
      for (int i = 0; i < 2; i++) begin
         trial = {r, d[DQ_W-1]};
         d = {d[DQ_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
            d[0] = 1'b1;
         end
         r = trial[VALUE_BITS-1:0];
      end

      dq_in   = dq_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         dq_in  = DQ_W'(dividend);
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(ITER);
      end else if (cnt_ff != '0) begin
         dq_in   = d;
         rem_in  = r;
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   // Hold operands and partial results
   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   // Iteration counter and completion pulse
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = dq_ff[VALUE_BITS-1:0];
   assign remainder = rem_ff;

endmodule

// ===== design/etot_datapath.sv =====
// ----------------------------------------------------------------------------
// etot_datapath
// Accumulator, cofactor, trial candidate and its square, plus the divider.
// ----------------------------------------------------------------------------
module etot_datapath #(
   parameter int VALUE_BITS = etot_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  etot_pkg::etot_cmd_type cmd,
   input  logic [VALUE_BITS-1:0]  value_in,
   output etot_pkg::etot_stat_type stat,
   output logic [VALUE_BITS-1:0]  totient
);

   localparam int SQ_W = 2 * VALUE_BITS;

   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [VALUE_BITS-1:0] rest_ff, rest_in;
   logic [VALUE_BITS-1:0] cand_ff, cand_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic                  hit_ff, hit_in;

   logic [VALUE_BITS-1:0] div_dividend;
   logic [VALUE_BITS-1:0] div_divisor;
   logic                  div_done;
   logic [VALUE_BITS-1:0] div_quot;
   logic [VALUE_BITS-1:0] div_rem;

   // Pick divider operands
   always_comb begin
      case (cmd.div_sel)
         etot_pkg::DIV_SEL_REST_CAND: begin
            div_dividend = rest_ff;
            div_divisor  = cand_ff;
         end
         etot_pkg::DIV_SEL_ACC_CAND: begin
            div_dividend = acc_ff;
            div_divisor  = cand_ff;
         end
         etot_pkg::DIV_SEL_ACC_REST: begin
            div_dividend = acc_ff;
            div_divisor  = rest_ff;
         end
         default: begin
            div_dividend = rest_ff;
            div_divisor  = cand_ff;
         end
      endcase
   end

   etot_div #(
      .VALUE_BITS(VALUE_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot),
      .remainder(div_rem)
   );

   // Update working registers on command
   always_comb begin
      acc_in  = acc_ff;
      rest_in = rest_ff;
      cand_in = cand_ff;
      sq_in   = sq_ff;
      hit_in  = hit_ff;
      if (cmd.load) begin
         acc_in  = value_in;
         rest_in = value_in;
         cand_in = VALUE_BITS'(2);
         sq_in   = SQ_W'(4);
         hit_in  = 1'b0;
      end else begin
         if (cmd.rest_upd) begin
            rest_in = div_quot;
         end
         if (cmd.hit_set) begin
            hit_in = 1'b1;
         end
         if (cmd.acc_upd) begin
            acc_in = acc_ff - div_quot;
         end
         // After two, test odd candidates only: (c+2)^2 = c^2 + 4c + 4
         if (cmd.advance) begin
            hit_in = 1'b0;
            if (cand_ff == VALUE_BITS'(2)) begin
               cand_in = VALUE_BITS'(3);
               sq_in   = SQ_W'(9);
            end else begin
               cand_in = cand_ff + VALUE_BITS'(2);
               sq_in   = sq_ff + (SQ_W'(cand_ff) << 2) + SQ_W'(4);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      rest_ff <= rest_in;
      cand_ff <= cand_in;
      sq_ff   <= sq_in;
      hit_ff  <= hit_in;
   end

   assign stat.sq_le_rest = (sq_ff <= SQ_W'(rest_ff));
   assign stat.rest_gt1   = (rest_ff > VALUE_BITS'(1));
   assign stat.div_done   = div_done;
   assign stat.rem_zero   = (div_rem == '0);
   assign stat.hit        = hit_ff;
   assign totient         = acc_ff;

endmodule

// ===== design/etot_ctrl.sv =====
// ----------------------------------------------------------------------------
// etot_ctrl
// Sequencer for the trial-division search and the final cofactor step.
// ----------------------------------------------------------------------------
module etot_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  etot_pkg::etot_stat_type stat,
   output etot_pkg::etot_cmd_type  cmd,
   output logic                    busy,
   output logic                    rsp_valid
);

   localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a transfer
   localparam logic [2:0] ST_CHECK = 3'd1;  // test candidate squared vs rest
   localparam logic [2:0] ST_RGO   = 3'd2;  // relaunch rest / candidate
   localparam logic [2:0] ST_DIVR  = 3'd3;  // wait on rest / candidate
   localparam logic [2:0] ST_DIVA  = 3'd4;  // wait on acc / candidate
   localparam logic [2:0] ST_FINAL = 3'd5;  // handle leftover prime cofactor
   localparam logic [2:0] ST_DIVF  = 3'd6;  // wait on acc / cofactor
   localparam logic [2:0] ST_DONE  = 3'd7;  // present the result

   logic [2:0] state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = etot_pkg::DIV_SEL_REST_CAND;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.sq_le_rest) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVR;
            end else begin
               state_in = ST_FINAL;
            end
         end
         ST_RGO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVR;
         end
         ST_DIVR: begin
            if (stat.div_done) begin
               if (stat.rem_zero) begin
                  // Divide the factor out again
                  cmd.rest_upd = 1'b1;
                  cmd.hit_set  = 1'b1;
                  state_in     = ST_RGO;
               end else if (stat.hit) begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = etot_pkg::DIV_SEL_ACC_CAND;
                  state_in      = ST_DIVA;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_CHECK;
               end
            end
         end
         ST_DIVA: begin
            if (stat.div_done) begin
               cmd.acc_upd = 1'b1;
               cmd.advance = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_FINAL: begin
            if (stat.rest_gt1) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = etot_pkg::DIV_SEL_ACC_REST;
               state_in      = ST_DIVF;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIVF: begin
            if (stat.div_done) begin
               cmd.acc_upd = 1'b1;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);

endmodule

// ===== design/euler_totient_top.sv =====
// ----------------------------------------------------------------------------
// euler_totient_top
// Euler totient phi(n) of an unsigned integer by trial division.
// ----------------------------------------------------------------------------
// Raise start for one cycle while busy is low to transfer req_value_in; busy
// then stays high until the result has been shown. The result appears on
// rsp_totient for exactly one cycle with rsp_valid high and cannot be held
// off, so the receiver must take it in that cycle. One item is worked on at
// a time. The time per item is set by the shared divider, which yields two
// quotient bits per cycle: each trial candidate (two, then odd numbers up to
// the square root of the remaining cofactor) costs one division of the
// cofactor, each repeated division by a found prime one more, each distinct
// prime found one more division to scale the accumulator, and a leftover
// prime cofactor one final division. Inputs zero and one return zero and one.
// ----------------------------------------------------------------------------
module euler_totient_top #(
   parameter int VALUE_BITS = etot_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value_in,
   output logic                  rsp_valid,
   output logic [VALUE_BITS-1:0] rsp_totient
);

   etot_pkg::etot_cmd_type  cmd;
   etot_pkg::etot_stat_type stat;

   etot_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy),
      .rsp_valid(rsp_valid)
   );

   etot_datapath #(
      .VALUE_BITS(VALUE_BITS)
   ) u_datapath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .value_in(req_value_in),
      .stat    (stat),
      .totient (rsp_totient)
   );

endmodule

// ===== design/etot_checker.sv =====
// ----------------------------------------------------------------------------
// etot_checker
// Port-level checks of the totient block, bound to the top level.
// ----------------------------------------------------------------------------
`include "euler_totient_top_assert.svh"

module etot_checker #(
   parameter int VALUE_BITS = etot_pkg::VALUE_BITS_DEFAULT
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic [VALUE_BITS-1:0] req_value_in,
   input logic                  rsp_valid,
   input logic [VALUE_BITS-1:0] rsp_totient
);

   // Result never exceeds the value that was transferred
   logic [VALUE_BITS-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         value_ff <= req_value_in;
      end
   end

   `ETOT_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid, "result strobe longer than one cycle")
   `ETOT_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy && !rsp_valid, "transfer did not start work")
   `ETOT_ASSERT_NEXT(a_done_idle, clock, reset, rsp_valid, !busy, "block still busy after result")
   `ETOT_ASSERT_IMPLY(a_result_busy, clock, reset, rsp_valid, busy && (rsp_totient <= value_ff), "result outside work or above input")

endmodule

bind euler_totient_top etot_checker #(
   .VALUE_BITS(VALUE_BITS)
) u_etot_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .req_value_in(req_value_in),
   .rsp_valid   (rsp_valid),
   .rsp_totient (rsp_totient)
);
